FILE: rtl/core/msps_pkg.sv
// Shared types and constants for the multichannel servo pulse sequencer.
// No dependencies; imported by msps_width_map, the top level and the bench.
`default_nettype none

package msps_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int POSITION_MAX = 180;

	localparam int OP_W    = 2;
	localparam int CH_W    = 4;
	localparam int VAL_W   = 12;
	localparam int PW_W    = 12;
	localparam int FRAME_W = 16;
	localparam int PIN_W   = 8;
	localparam int SLOT_W  = 4;
	localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// APB register file
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		REG_MIN_PULSE     = 2'd0,
		REG_MAX_PULSE     = 2'd1,
		REG_DEFAULT_PULSE = 2'd2,
		REG_FRAME_PERIOD  = 2'd3
	} reg_idx_t;

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_ATTACH = 2'd2,
		OP_DETACH = 2'd3
	} opcode_t;

	localparam logic [PW_W-1:0]    MIN_PULSE_RST     = 12'd544;
	localparam logic [PW_W-1:0]    MAX_PULSE_RST     = 12'd2400;
	localparam logic [PW_W-1:0]    DEFAULT_PULSE_RST = 12'd1500;
	localparam logic [FRAME_W-1:0] FRAME_PERIOD_RST  = 16'd20000;

	// channel widths after reset: default clamped to the reset limits
	localparam logic [PW_W-1:0] WIDTH_RST =
		(DEFAULT_PULSE_RST < MIN_PULSE_RST) ? MIN_PULSE_RST :
		(DEFAULT_PULSE_RST > MAX_PULSE_RST) ? MAX_PULSE_RST : DEFAULT_PULSE_RST;

	// position map: |value * span| fits MAP_PROD_W bits; divide by POSITION_MAX
	// via exact reciprocal multiply (ceil(2^S / P), S = prod bits + log2 P)
	localparam int MAP_PROD_W = $clog2(POSITION_MAX * ((1 << PW_W) - 1) + 1);
	localparam int DIV_SHIFT  = MAP_PROD_W + $clog2(POSITION_MAX);
	localparam int DIV_MULT_W = DIV_SHIFT - $clog2(POSITION_MAX) + 1;
	localparam logic [DIV_MULT_W-1:0] DIV_MULT = DIV_MULT_W'(
		((longint'(1) << DIV_SHIFT) + longint'(POSITION_MAX) - 1) / longint'(POSITION_MAX));

	typedef struct packed {
		logic [VAL_W-1:0]      value;
		logic                  in_range;
		logic [MAP_PROD_W-1:0] prod_mag;
		logic                  span_neg;
	} map_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/msps_width_map.sv
// Pulse width map and clamp: divides the registered product by the position
// range, offsets by min_pulse (raw above range), clamps. Depends on msps_pkg.
`default_nettype none

module msps_width_map (
	input  msps_pkg::map_req_t         req,
	input  logic [msps_pkg::PW_W-1:0]  min_pulse,
	input  logic [msps_pkg::PW_W-1:0]  max_pulse,
	output logic [msps_pkg::PW_W-1:0]  width
);
	import msps_pkg::*;

	localparam int RECIP_W = MAP_PROD_W + DIV_MULT_W;

	logic [RECIP_W-1:0]     recip;
	logic [PW_W-1:0]        quot;
	logic signed [PW_W+1:0] min_s;
	logic signed [PW_W+1:0] max_s;
	logic signed [PW_W+1:0] quot_s;
	logic signed [PW_W+1:0] mapped;
	logic signed [PW_W+1:0] pw;

	assign recip  = RECIP_W'(req.prod_mag) * RECIP_W'(DIV_MULT);
	assign quot   = PW_W'(recip >> DIV_SHIFT);
	assign min_s  = $signed({2'b00, min_pulse});
	assign max_s  = $signed({2'b00, max_pulse});
	assign quot_s = $signed({2'b00, quot});
	// downward map when limits are inverted; truncates toward zero
	assign mapped = req.span_neg ? (min_s - quot_s) : (min_s + quot_s);
	assign pw     = req.in_range ? mapped : $signed({2'b00, req.value});

	always_comb begin
		priority if (pw < min_s) begin
			width = min_pulse;
		end else if (pw > max_s) begin
			width = max_pulse;
		end else begin
			width = pw[PW_W-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/multichannel_servo_pulse_sequencer.sv
// Top level of the multichannel servo pulse sequencer: APB registers, input
// stage, sequencer state and output register. Depends on msps_pkg, msps_width_map.
`default_nettype none

// Usage
//   Input channel (in_valid/in_ready): one word per operation - a one
//   microsecond tick, a width write, an attach or a detach for a channel.
//   Output channel (out_valid/out_ready): exactly one word per input word,
//   in order: pin levels, active slot, frame start mark, and the stored
//   width and attach flag of the named channel after the operation.
//   A word accepted into the first stage reaches the output register when the
//   second stage advances; one word per cycle while out_ready is high. The
//   first stage holds the word plus the value*span product; the second stage
//   does the reciprocal divide, clamp and state update into the output register.
//   Stall: while out_ready is low the output word holds; one more word can
//   sit in the first stage, then in_ready drops. in_ready follows out_ready
//   combinationally when both stages are full.
//   Reset (arst_n low): registers take their reset values, all channels get
//   width 1500 and are detached, the sequencer sits in the sync gap with
//   both counters at zero. No clearing pass; words are taken right away.
//   Registers (APB, byte address 4*i): min_pulse, max_pulse, default_pulse,
//   frame_period. Write them only while the block is idle.
module multichannel_servo_pulse_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [msps_pkg::ADDR_W-1:0]    paddr,
	input  logic [msps_pkg::DATA_W-1:0]    pwdata,
	output logic [msps_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	// input words
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [msps_pkg::OP_W-1:0]      opcode,
	input  logic [msps_pkg::CH_W-1:0]      channel,
	input  logic [msps_pkg::VAL_W-1:0]     value,
	// result words
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [msps_pkg::PIN_W-1:0]     pins,
	output logic [msps_pkg::SLOT_W-1:0]    active_slot,
	output logic                           frame_start,
	output logic [msps_pkg::PW_W-1:0]      read_width,
	output logic                           is_attached
);
	import msps_pkg::*;

	// ---------------- configuration registers ----------------
	logic [PW_W-1:0]    min_pulse_q;
	logic [PW_W-1:0]    max_pulse_q;
	logic [PW_W-1:0]    default_pulse_q;
	logic [FRAME_W-1:0] frame_period_q;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q     <= MIN_PULSE_RST;
			max_pulse_q     <= MAX_PULSE_RST;
			default_pulse_q <= DEFAULT_PULSE_RST;
			frame_period_q  <= FRAME_PERIOD_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_MIN_PULSE:     min_pulse_q     <= pwdata[PW_W-1:0];
				REG_MAX_PULSE:     max_pulse_q     <= pwdata[PW_W-1:0];
				REG_DEFAULT_PULSE: default_pulse_q <= pwdata[PW_W-1:0];
				REG_FRAME_PERIOD:  frame_period_q  <= pwdata[FRAME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_MIN_PULSE:     prdata = DATA_W'(min_pulse_q);
			REG_MAX_PULSE:     prdata = DATA_W'(max_pulse_q);
			REG_DEFAULT_PULSE: prdata = DATA_W'(default_pulse_q);
			REG_FRAME_PERIOD:  prdata = DATA_W'(frame_period_q);
			default:           prdata = '0;
		endcase
	end

	// ---------------- handshake ----------------
	logic s1_valid_q;
	logic out_valid_q;
	logic in_fire;
	logic adv;

	assign adv      = s1_valid_q & (~out_valid_q | out_ready);
	assign in_ready = ~s1_valid_q | adv;
	assign in_fire  = in_valid & in_ready;

	// ---------------- stage 1: capture word, value*span ----------------
	logic                span_neg;
	logic [PW_W-1:0]     span_mag;
	logic [2*PW_W-1:0]   prod_full;
	map_req_t            map_req;

	opcode_t             s1_op;
	logic [CH_W-1:0]     s1_ch;
	map_req_t            s1_map;

	assign span_neg  = min_pulse_q > max_pulse_q;
	assign span_mag  = span_neg ? (min_pulse_q - max_pulse_q) : (max_pulse_q - min_pulse_q);
	assign prod_full = (2*PW_W)'(value) * (2*PW_W)'(span_mag);

	always_comb begin
		map_req.value    = value;
		map_req.in_range = value <= VAL_W'(POSITION_MAX);
		map_req.prod_mag = MAP_PROD_W'(prod_full);
		map_req.span_neg = span_neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			s1_op  <= opcode_t'(opcode);
			s1_ch  <= channel;
			s1_map <= map_req;
		end
	end

	// ---------------- stage 2: map, sequencer, state update ----------------
	logic [PW_W-1:0] new_width;

	msps_width_map u_map (
		.req       (s1_map),
		.min_pulse (min_pulse_q),
		.max_pulse (max_pulse_q),
		.width     (new_width)
	);

	logic [PW_W-1:0]         widths_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] attach_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [FRAME_W-1:0]      slot_el_q;
	logic [FRAME_W-1:0]      frame_el_q;

	logic [PW_W-1:0]         widths_n [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] attach_n;
	logic [SLOT_W-1:0]       slot_n;
	logic [FRAME_W-1:0]      slot_el_n;
	logic [FRAME_W-1:0]      frame_el_n;
	logic                    fstart_n;
	logic [PIN_W-1:0]        pins_n;
	logic [PW_W-1:0]         rd_width_n;
	logic                    rd_att_n;

	logic                    chan_ok;
	logic [CH_IDX_W-1:0]     ch_idx;
	logic                    slot_ok;
	logic [CH_IDX_W-1:0]     slot_idx;
	logic [CH_W-1:0]         ch_m1;
	logic [SLOT_W-1:0]       slot_m1;

	assign chan_ok  = (s1_ch >= CH_W'(1)) && (s1_ch <= CH_W'(NUM_CHANNELS));
	assign ch_m1    = s1_ch - CH_W'(1);
	assign ch_idx   = ch_m1[CH_IDX_W-1:0];
	assign slot_ok  = (slot_q >= SLOT_W'(1)) && (slot_q <= SLOT_W'(NUM_CHANNELS));
	assign slot_m1  = slot_q - SLOT_W'(1);
	assign slot_idx = slot_m1[CH_IDX_W-1:0];

	always_comb begin
		widths_n   = widths_q;
		attach_n   = attach_q;
		slot_n     = slot_q;
		slot_el_n  = slot_el_q;
		frame_el_n = frame_el_q;
		fstart_n   = 1'b0;

		unique case (s1_op)
			OP_TICK: begin
				// saturating microsecond counters
				frame_el_n = (frame_el_q == '1) ? frame_el_q : frame_el_q + FRAME_W'(1);
				slot_el_n  = (slot_el_q == '1) ? slot_el_q : slot_el_q + FRAME_W'(1);
				if (slot_ok) begin
					// zero width still costs one tick: compare after increment
					if (slot_el_n >= FRAME_W'(widths_q[slot_idx])) begin
						slot_n    = (slot_q == SLOT_W'(NUM_CHANNELS)) ? '0 : slot_q + SLOT_W'(1);
						slot_el_n = '0;
					end
				end else begin
					slot_n = '0;
				end
				// sync gap ends once the frame period has run (stretches on overrun)
				if (slot_n == '0 && frame_el_n >= frame_period_q) begin
					slot_n     = SLOT_W'(1);
					slot_el_n  = '0;
					frame_el_n = '0;
					fstart_n   = 1'b1;
				end
			end
			OP_WRITE: begin
				if (chan_ok) widths_n[ch_idx] = new_width;
			end
			OP_ATTACH: begin
				if (chan_ok) attach_n[ch_idx] = 1'b1;
			end
			OP_DETACH: begin
				if (chan_ok) attach_n[ch_idx] = 1'b0;
			end
			default: ;
		endcase

		pins_n = '0;
		for (int i = 0; i < PIN_W; i++) begin
			if (i < NUM_CHANNELS) begin
				pins_n[i] = (slot_n == SLOT_W'(i + 1)) && attach_n[i];
			end
		end

		rd_width_n = chan_ok ? widths_n[ch_idx] : '0;
		rd_att_n   = chan_ok ? attach_n[ch_idx] : 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				widths_q[i] <= WIDTH_RST;
			end
			attach_q   <= '0;
			slot_q     <= '0;
			slot_el_q  <= '0;
			frame_el_q <= '0;
		end else if (adv) begin
			widths_q   <= widths_n;
			attach_q   <= attach_n;
			slot_q     <= slot_n;
			slot_el_q  <= slot_el_n;
			frame_el_q <= frame_el_n;
		end
	end

	// ---------------- output register ----------------
	logic [PIN_W-1:0]  pins_q;
	logic [SLOT_W-1:0] slot_out_q;
	logic              fstart_q;
	logic [PW_W-1:0]   rd_width_q;
	logic              rd_att_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= adv | (out_valid_q & ~out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pins_q     <= pins_n;
			slot_out_q <= slot_n;
			fstart_q   <= fstart_n;
			rd_width_q <= rd_width_n;
			rd_att_q   <= rd_att_n;
		end
	end

	assign out_valid   = out_valid_q;
	assign pins        = pins_q;
	assign active_slot = slot_out_q;
	assign frame_start = fstart_q;
	assign read_width  = rd_width_q;
	assign is_attached = rd_att_q;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for multichannel_servo_pulse_sequencer: queued stimulus, clocked
// driver, receiver and monitor, and a word-by-word model of widths, attach flags and sequencing.
// Depends on msps_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;
	import msps_pkg::*;

	localparam int CYCLE_LIMIT = 200000;  // watchdog limit, in cycles
	localparam int LONG_HOLD   = 300;     // receiver back-pressure stretch, in cycles
	localparam int DRAIN_WAIT  = 8;       // margin for the pipe to go quiet after the queues drain

	// one input word and the result word it produces
	typedef struct packed {
		opcode_t          op;
		logic [CH_W-1:0]  chan;
		logic [VAL_W-1:0] val;
	} servo_word_t;

	typedef struct packed {
		logic [PIN_W-1:0]  pins;
		logic [SLOT_W-1:0] slot;
		logic              fstart;
		logic [PW_W-1:0]   width;
		logic              attached;
	} servo_result_t;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_STEADY,  // ready every cycle
		RX_HALF,    // coin flip
		RX_MOSTLY,  // ready unless a 0..6 draw comes up zero
		RX_SPARSE   // ready only when a 0..4 draw comes up zero
	} rx_mode_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	always #4 clk = ~clk;

	// APB side, idle until a register write
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [DATA_W-1:0] pwdata  = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// word channels
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic [OP_W-1:0]   opcode    = '0;
	logic [CH_W-1:0]   channel   = '0;
	logic [VAL_W-1:0]  value     = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [PIN_W-1:0]  pins;
	logic [SLOT_W-1:0] active_slot;
	logic              frame_start;
	logic [PW_W-1:0]   read_width;
	logic              is_attached;

	multichannel_servo_pulse_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .channel(channel), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.pins(pins), .active_slot(active_slot), .frame_start(frame_start),
		.read_width(read_width), .is_attached(is_attached)
	);

	// ------------------------------------------------------------------
	// Model state: register copies plus the sequencer itself
	// ------------------------------------------------------------------
	logic [PW_W-1:0]    lim_min    = MIN_PULSE_RST;
	logic [PW_W-1:0]    lim_max    = MAX_PULSE_RST;
	logic [PW_W-1:0]    dflt_width = DEFAULT_PULSE_RST;
	logic [FRAME_W-1:0] frame_len  = FRAME_PERIOD_RST;

	logic [PW_W-1:0]    chan_width [NUM_CHANNELS];
	logic               chan_attached [NUM_CHANNELS];
	logic [SLOT_W-1:0]  slot_now    = '0;
	logic [FRAME_W-1:0] slot_ticks  = '0;
	logic [FRAME_W-1:0] frame_ticks = '0;

	servo_word_t   pending_words[$];     // filled by the stimulus, drained by the driver
	servo_result_t expected_results[$];  // one per accepted word, oldest first

	int unsigned errors       = 0;
	int unsigned words_sent   = 0;
	int unsigned words_seen   = 0;
	int unsigned frames_model = 0;
	int unsigned settings_run = 0;
	int unsigned cycles       = 0;
	int unsigned hold_req     = 0;  // bumped by stimulus, served by the receiver

	// clamp order matters with inverted limits: floor first, ceiling only otherwise
	function automatic logic [PW_W-1:0] clamp_width(longint pw);
		if (pw < longint'(lim_min))
			pw = longint'(lim_min);
		else if (pw > longint'(lim_max))
			pw = longint'(lim_max);
		return PW_W'(pw);
	endfunction

	// Apply one word to the model and return the result word it should yield.
	function automatic servo_result_t advance_servo(servo_word_t w);
		servo_result_t r;
		logic          named;
		int            idx;
		longint        span;
		longint        pw;
		r     = '0;
		named = (w.chan >= 1) && (w.chan <= NUM_CHANNELS);
		idx   = int'(w.chan) - 1;
		if (w.op == OP_TICK) begin
			if (frame_ticks != '1)
				frame_ticks++;
			if (slot_ticks != '1)
				slot_ticks++;
			if (slot_now >= 1 && slot_now <= NUM_CHANNELS) begin
				// a zero width still leaves the slot after one tick
				if (slot_ticks >= FRAME_W'(chan_width[slot_now - 1])) begin
					slot_now   = slot_now + 1;
					slot_ticks = '0;
					if (slot_now > NUM_CHANNELS)
						slot_now = '0;
				end
			end else begin
				slot_now = '0;
			end
			// sync gap ends once the frame is long enough; an overrun ends it on the same tick
			if (slot_now == 0 && frame_ticks >= frame_len) begin
				slot_now    = 1;
				slot_ticks  = '0;
				frame_ticks = '0;
				r.fstart    = 1'b1;
				frames_model++;
			end
		end else if (named) begin
			case (w.op)
				OP_WRITE: begin
					pw = longint'(w.val);
					// positions map linearly, truncating toward zero; larger values are raw us
					if (w.val <= POSITION_MAX) begin
						span = longint'(lim_max) - longint'(lim_min);
						pw   = (longint'(w.val) * span) / POSITION_MAX + longint'(lim_min);
					end
					chan_width[idx] = clamp_width(pw);
				end
				OP_ATTACH: chan_attached[idx] = 1'b1;
				default:   chan_attached[idx] = 1'b0;
			endcase
		end
		for (int i = 0; i < NUM_CHANNELS && i < PIN_W; i++)
			if (slot_now == i + 1 && chan_attached[i])
				r.pins[i] = 1'b1;
		r.slot = slot_now;
		if (named) begin
			r.width    = chan_width[idx];
			r.attached = chan_attached[idx];
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Driver: bursts of words from the pending queue, random gaps between
	// ------------------------------------------------------------------
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		logic offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			offer = in_valid;
			if (in_valid && in_ready) begin
				// accepted: the model sees the word in acceptance order
				expected_results.push_back(advance_servo(pending_words.pop_front()));
				words_sent++;
				offer = 1'b0;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
				end
			end
			if (!offer) begin
				if (gap_left > 0)
					gap_left--;
				else if (pending_words.size() > 0)
					offer = 1'b1;
			end
			// single assignment per signal per edge; a held word keeps the same head
			in_valid <= offer;
			if (offer) begin
				opcode  <= pending_words[0].op;
				channel <= pending_words[0].chan;
				value   <= pending_words[0].val;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stall pattern is redrawn at random; a request
	// from the stimulus forces a long hold-off so the pipe backs up
	// ------------------------------------------------------------------
	int unsigned hold_ack  = 0;
	int unsigned hold_left = 0;
	int unsigned mode_left = 0;
	rx_mode_t    rx_mode   = RX_STEADY;

	always @(posedge clk or negedge arst_n) begin
		logic rdy;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (hold_ack != hold_req) begin
				hold_ack  = hold_req;
				hold_left = LONG_HOLD;
			end
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				case (rx_mode)
					RX_STEADY: rdy = 1'b1;
					RX_HALF:   rdy = $urandom_range(0, 1);
					RX_MOSTLY: rdy = ($urandom_range(0, 6) != 0);
					default:   rdy = ($urandom_range(0, 4) == 0);
				endcase
			end
			out_ready <= rdy;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: every accepted result word against the oldest expectation
	// ------------------------------------------------------------------
	task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
		$display("%0t ns: result %0d %s: got %0d, want %0d", $realtime, words_seen, what,
			got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		servo_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				flag_mismatch("arrived with nothing expected", 1, 0);
			end else begin
				want = expected_results.pop_front();
				if (pins !== want.pins)
					flag_mismatch("pins", pins, want.pins);
				if (active_slot !== want.slot)
					flag_mismatch("active_slot", active_slot, want.slot);
				if (frame_start !== want.fstart)
					flag_mismatch("frame_start", frame_start, want.fstart);
				if (read_width !== want.width)
					flag_mismatch("read_width", read_width, want.width);
				if (is_attached !== want.attached)
					flag_mismatch("is_attached", is_attached, want.attached);
			end
			words_seen++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected", cycles,
				expected_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// APB write, then read back; the model register changes at the write edge.
	// Bits above the register width are junk and must be dropped.
	task automatic write_reg(reg_idx_t r, logic [DATA_W-1:0] data);
		logic [DATA_W-1:0] mask;
		mask = (r == REG_FRAME_PERIOD) ? DATA_W'(16'hFFFF) : DATA_W'(12'hFFF);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(int'(r) * 4);
		pwdata  <= (DATA_W'($urandom) & ~mask) | (data & mask);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (r)
			REG_MIN_PULSE:     lim_min    = data[PW_W-1:0];
			REG_MAX_PULSE:     lim_max    = data[PW_W-1:0];
			REG_DEFAULT_PULSE: dflt_width = data[PW_W-1:0];  // never reloads a channel
			default:           frame_len  = data[FRAME_W-1:0];
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== (data & mask)) begin
			$display("%0t ns: register %s reads %0d, wrote %0d", $realtime, r.name(),
				prdata, data & mask);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// write values: random positions, the edges of the map, and random 12-bit values that are mostly raw microseconds
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return VAL_W'(0);
			1:       return VAL_W'(POSITION_MAX);
			2:       return VAL_W'(POSITION_MAX + 1);
			3, 4, 5: return VAL_W'($urandom_range(0, POSITION_MAX));
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic servo_word_t random_word();
		servo_word_t w;
		int unsigned k;
		k      = $urandom_range(0, 99);
		w.chan = ($urandom_range(0, 7) == 0) ? CH_W'($urandom_range(0, 15))
		                                     : CH_W'($urandom_range(1, NUM_CHANNELS));
		w.val  = VAL_W'($urandom);
		if (k < 68)
			w.op = OP_TICK;
		else if (k < 82)
			w.op = OP_WRITE;
		else if (k < 91)
			w.op = OP_ATTACH;
		else
			w.op = OP_DETACH;
		if (w.op == OP_WRITE)
			w.val = pick_value();
		return w;
	endfunction

	// Widths left over from the last setting may sit far outside the new limits,
	// so each setting opens by rewriting every channel, then random traffic.
	task automatic queue_phase(int unsigned n);
		servo_word_t w;
		for (int c = 1; c <= NUM_CHANNELS; c++) begin
			w.op   = OP_WRITE;
			w.chan = CH_W'(c);
			w.val  = pick_value();
			pending_words.push_back(w);
			if ($urandom_range(0, 1)) begin
				w.op = OP_ATTACH;
				pending_words.push_back(w);
			end
		end
		repeat (n)
			pending_words.push_back(random_word());
		settings_run++;
	endtask

	// wait until every word is in and every result out, then let the pipe go quiet
	task automatic settle();
		while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT)
			@(negedge clk);
	endtask

	task automatic push_word(opcode_t op, int unsigned ch, int unsigned val);
		servo_word_t w;
		w.op   = op;
		w.chan = CH_W'(ch);
		w.val  = VAL_W'(val);
		pending_words.push_back(w);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			chan_width[i]    = clamp_width(longint'(dflt_width));
			chan_attached[i] = 1'b0;
		end
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, reset limits 544..2400: map ends, midpoint, raw values on both
		// sides of the clamp, channel none and out of range, attach/detach.
		push_word(OP_TICK, 1, 0);                // reset width readback
		push_word(OP_WRITE, 1, 0);               // map low end
		push_word(OP_WRITE, 2, POSITION_MAX);    // map high end
		push_word(OP_WRITE, 3, 90);              // midpoint
		push_word(OP_WRITE, 4, POSITION_MAX + 1);// raw, below floor
		push_word(OP_WRITE, 5, 4095);            // raw, above ceiling
		push_word(OP_WRITE, 6, 2000);            // raw, in range
		push_word(OP_WRITE, 7, 179);
		push_word(OP_WRITE, 0, 77);              // channel none: ignored
		push_word(OP_WRITE, 9, 100);             // out of range: ignored
		push_word(OP_WRITE, 15, 4095);
		push_word(OP_ATTACH, 1, 0);
		push_word(OP_ATTACH, 8, 4095);
		push_word(OP_ATTACH, 0, 0);
		push_word(OP_ATTACH, 12, 1);
		push_word(OP_DETACH, 8, 0);
		push_word(OP_DETACH, 14, 0);
		push_word(OP_ATTACH, 8, 0);
		push_word(OP_TICK, 3, 4095);             // tick reads the named channel too
		push_word(OP_TICK, 8, 0);
		push_word(OP_TICK, 0, 4095);
		push_word(OP_DETACH, 1, 2048);
		settle();

		// short pulses, frame of 12 us: sync gaps and overruns both happen
		write_reg(REG_MIN_PULSE, 0);
		write_reg(REG_MAX_PULSE, 3);
		write_reg(REG_FRAME_PERIOD, 12);
		queue_phase(300);
		hold_req++;  // receiver backs off while the driver keeps offering
		settle();

		// all widths zero, zero frame period: one tick per slot, frame restarts at once
		write_reg(REG_MAX_PULSE, 0);
		write_reg(REG_FRAME_PERIOD, 0);
		write_reg(REG_DEFAULT_PULSE, 0);
		queue_phase(150);
		settle();

		// inverted limits: map runs downward, clamp floor wins
		write_reg(REG_MIN_PULSE, 5);
		write_reg(REG_MAX_PULSE, 2);
		write_reg(REG_FRAME_PERIOD, 30);
		queue_phase(200);
		settle();

		// moderate widths, roomy frame; default register changes nothing now
		write_reg(REG_MIN_PULSE, 1);
		write_reg(REG_MAX_PULSE, 6);
		write_reg(REG_FRAME_PERIOD, 40);
		write_reg(REG_DEFAULT_PULSE, 4095);
		queue_phase(250);
		hold_req++;
		settle();

		// widest limits and longest frame: few words, the frame never completes
		write_reg(REG_MIN_PULSE, 0);
		write_reg(REG_MAX_PULSE, 4095);
		write_reg(REG_FRAME_PERIOD, 65535);
		queue_phase(30);
		settle();

		// both limits at the top
		write_reg(REG_MIN_PULSE, 4095);
		write_reg(REG_FRAME_PERIOD, 100);
		queue_phase(20);
		settle();

		repeat (DRAIN_WAIT)
			@(posedge clk);
		$display("sent %0d words over %0d register settings plus a directed set;", words_sent,
			settings_run);
		$display("compared %0d results, %0d frame starts, %0d mismatches", words_seen,
			frames_model, errors);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
